// File: rtl/core/pgs_pkg.sv
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared types and constants of the Gauss-Seidel Poisson sweep block.
// ----------------------------------------------------------------------------
package pgs_pkg;

  localparam int GRID_SIZE = 64;
  localparam int IDX_W     = $clog2(GRID_SIZE);
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int VAL_W     = 32;
  localparam int WORD_W    = VAL_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;
  localparam int STEP_W    = 16;
  localparam int RAD_W     = 20;
  localparam int SQ_W      = 2 * IDX_W;
  localparam int M_W       = SQ_W + 4;
  localparam int H2_W      = 2 * STEP_W;
  localparam int H4_W      = 2 * H2_W - 15;
  localparam int MAG_W     = 41;
  localparam int TERM_W    = MAG_W + 1;
  localparam int ACC_W     = TERM_W + 2;

  localparam logic signed [VAL_W-1:0] ONE_Q16  = 32'sh0001_0000;
  localparam logic [MAG_W-1:0]        TERM_CAP = 41'h100_0000_0000;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_SWEEP = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_GRID_STEP = 2'd0,
    REG_INNER_R2  = 2'd1,
    REG_OUTER_R2  = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_H2,
    ST_H4,
    ST_INIT_MUL,
    ST_INIT_WR,
    ST_SWEEP,
    ST_READ,
    ST_DONE
  } state_e;

  // sweep sub-steps: centre read, four neighbor reads, a load, then write
  typedef enum logic [2:0] {
    SS_C  = 3'd0,
    SS_N  = 3'd1,
    SS_S  = 3'd2,
    SS_W  = 3'd3,
    SS_E  = 3'd4,
    SS_LD = 3'd5,
    SS_WR = 3'd6,
    SS_XX = 3'd7
  } sstep_e;

endpackage

// File: rtl/core/pgs_if.sv
// ----------------------------------------------------------------------------
// pgs interfaces
// Valid/ready channels for configuration, commands and results.
// ----------------------------------------------------------------------------
interface pgs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface pgs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [5:0] row;
  logic [5:0] col;
  modport source (output valid, opcode, row, col, input ready);
  modport sink   (input valid, opcode, row, col, output ready);
endinterface

interface pgs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cell_value;
  logic               cell_inside;
  modport source (output valid, cell_value, cell_inside, input ready);
  modport sink   (input valid, cell_value, cell_inside, output ready);
endinterface

// File: rtl/core/poisson_gauss_seidel_sweep.sv
// ----------------------------------------------------------------------------
// poisson_gauss_seidel_sweep
// Five-point Gauss-Seidel Poisson relaxation on an annulus, grid held in RAM.
// ----------------------------------------------------------------------------
// One word at a time. A read (opcode 2) goes through ST_READ and ST_DONE to
// the result register, a no-op through ST_DONE alone. Initialise visits every
// cell in ST_INIT_MUL then ST_INIT_WR. A sweep skips an inner cell outside the
// region after its centre read; each inside cell needs five reads through the
// single read port of the grid RAM before its write-back. The result register
// lets a finished result wait while the next word is accepted.
module poisson_gauss_seidel_sweep (
  input  logic      clk_i,
  input  logic      rst_ni,
  pgs_cfg_if.sink   cfg_i,
  pgs_in_if.sink    in_i,
  pgs_out_if.source out_o
);
  import pgs_pkg::*;

  state_e state_q, state_d;
  sstep_e step_q;
  opcode_e op_q;
  logic rd_ok_q;
  logic [IDX_W-1:0] row_q, col_q;

  logic [STEP_W-1:0] grid_step_q;
  logic [RAD_W-1:0]  inner_q, outer_q;

  logic [H2_W-1:0] h2_q;
  logic [H4_W-1:0] h4_q;

  logic        out_valid_q;
  logic signed [VAL_W-1:0] out_value_q;
  logic        out_inside_q;

  // RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  pgs_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // coordinates
  logic signed [IDX_W:0]     ki, kj;
  logic signed [2*IDX_W+1:0] ki_p, kj_p;
  logic [SQ_W-1:0]           ki_sq, kj_sq;
  logic [SQ_W:0]             r2_idx;
  logic signed [SQ_W+1:0]    d_s;
  logic [SQ_W:0]             d_abs;
  logic [M_W-1:0]            m_d;

  assign ki     = $signed({1'b0, row_q}) - $signed((IDX_W+1)'(GRID_SIZE / 2));
  assign kj     = $signed({1'b0, col_q}) - $signed((IDX_W+1)'(GRID_SIZE / 2));
  assign ki_p   = ki * ki;
  assign kj_p   = kj * kj;
  assign ki_sq  = ki_p[SQ_W-1:0];
  assign kj_sq  = kj_p[SQ_W-1:0];
  assign r2_idx = {1'b0, ki_sq} + {1'b0, kj_sq};
  assign d_s    = $signed({2'b00, ki_sq}) - $signed({2'b00, kj_sq});
  assign d_abs  = d_s[SQ_W+1] ? (SQ_W+1)'(-d_s) : d_s[SQ_W:0];
  assign m_d    = (M_W'(d_abs) << 3) + (M_W'(d_abs) << 2);

  // init region test
  logic [SQ_W+H2_W:0] r2_q;
  logic               border_q;
  logic [SQ_W+H2_W:0] lo_r2, hi_r2;
  logic               in_reg;

  assign lo_r2  = (SQ_W+H2_W+1)'({inner_q, 12'b0});
  assign hi_r2  = (SQ_W+H2_W+1)'({outer_q, 12'b0});
  assign in_reg = !border_q && (r2_q >= lo_r2) && (r2_q <= hi_r2);

  // source term
  logic [M_W-1:0]       m_q;
  logic                 neg_q;
  logic [M_W+31:0]      pl_q;
  logic [M_W+H4_W-33:0] ph_q;
  logic [M_W+H4_W:0]    prod;
  logic [M_W+H4_W-16:0] rnd;
  logic [MAG_W-1:0]     mag;
  logic signed [TERM_W-1:0] term_q;

  assign prod = (M_W+H4_W+1)'(pl_q) + ((M_W+H4_W+1)'(ph_q) << 32);
  assign rnd  = (M_W+H4_W-15)'((prod + (M_W+H4_W+1)'(32768)) >> 16);
  assign mag  = (rnd > (M_W+H4_W-15)'(TERM_CAP)) ? TERM_CAP : rnd[MAG_W-1:0];

  // relaxation update
  logic signed [VAL_W-1:0] n_q, s_q, w_q, e_q;
  logic signed [ACC_W-1:0] acc, acc_q4;
  logic signed [VAL_W-1:0] new_val;

  assign acc    = ACC_W'(n_q) + ACC_W'(s_q) + ACC_W'(w_q) + ACC_W'(e_q)
                - ACC_W'(term_q) + ACC_W'(2);
  assign acc_q4 = acc >>> 2;
  always_comb begin
    if (acc_q4 > ACC_W'(32'sh7fff_ffff)) begin
      new_val = 32'sh7fff_ffff;
    end else if (acc_q4 < -ACC_W'(33'sh0_8000_0000)) begin
      new_val = -32'sh7fff_ffff - 32'sh1;
    end else begin
      new_val = acc_q4[VAL_W-1:0];
    end
  end

  logic last_inner, last_cell, skip_cell, out_free, in_acc;
  assign last_inner = (row_q == IDX_W'(GRID_SIZE - 2)) && (col_q == IDX_W'(GRID_SIZE - 2));
  assign last_cell  = (row_q == IDX_W'(GRID_SIZE - 1)) && (col_q == IDX_W'(GRID_SIZE - 1));
  assign skip_cell  = (step_q == SS_N) && !ram_rdata[VAL_W];
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (opcode_e'(in_i.opcode))
            OP_INIT, OP_SWEEP: state_d = ST_H2;
            OP_READ:           state_d = ST_READ;
            OP_NOP:            state_d = ST_DONE;
          endcase
        end
      end
      ST_H2:       state_d = (op_q == OP_SWEEP) ? ST_H4 : ST_INIT_MUL;
      ST_H4:       state_d = ST_SWEEP;
      ST_INIT_MUL: state_d = ST_INIT_WR;
      ST_INIT_WR:  state_d = last_cell ? ST_DONE : ST_INIT_MUL;
      ST_SWEEP: begin
        if (last_inner && (skip_cell || step_q == SS_WR)) begin
          state_d = ST_DONE;
        end
      end
      ST_READ:     state_d = ST_DONE;
      ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
    endcase
  end

  // outputs and memory port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {row_q, col_q};
    ram_wdata = {1'b1, new_val};
    ram_raddr = {row_q, col_q};
    unique case (state_q)
      ST_INIT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {in_reg, in_reg ? ONE_Q16 : {VAL_W{1'b0}}};
      end
      ST_SWEEP: begin
        ram_we = (step_q == SS_WR);
        unique case (step_q)
          SS_N:    ram_raddr = {row_q - IDX_W'(1), col_q};
          SS_S:    ram_raddr = {row_q + IDX_W'(1), col_q};
          SS_W:    ram_raddr = {row_q, col_q - IDX_W'(1)};
          SS_E:    ram_raddr = {row_q, col_q + IDX_W'(1)};
          default: ram_raddr = {row_q, col_q};
        endcase
      end
      default: begin
      end
    endcase
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.cell_value  = out_value_q;
  assign out_o.cell_inside = out_inside_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= SS_C;
      op_q        <= OP_NOP;
      row_q       <= '0;
      col_q       <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      grid_step_q <= 16'd819;
      inner_q     <= 20'd16384;
      outer_q     <= 20'd102400;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        unique case (cfg_reg_e'(cfg_i.index))
          REG_GRID_STEP: grid_step_q <= cfg_i.data[STEP_W-1:0];
          REG_INNER_R2:  inner_q     <= cfg_i.data;
          REG_OUTER_R2:  outer_q     <= cfg_i.data;
          REG_UNUSED:    ;
        endcase
      end
      if (out_valid_q && out_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q    <= opcode_e'(in_i.opcode);
            row_q   <= IDX_W'(in_i.row);
            col_q   <= IDX_W'(in_i.col);
            rd_ok_q <= ({1'b0, in_i.row} < 7'(GRID_SIZE)) && ({1'b0, in_i.col} < 7'(GRID_SIZE));
          end
        end
        ST_H2: begin
          row_q <= (op_q == OP_SWEEP) ? IDX_W'(1) : '0;
          col_q <= (op_q == OP_SWEEP) ? IDX_W'(1) : '0;
        end
        ST_H4: step_q <= SS_C;
        ST_INIT_WR: {row_q, col_q} <= {row_q, col_q} + ADDR_W'(1);
        ST_SWEEP: begin
          if (skip_cell || step_q == SS_WR) begin
            step_q <= SS_C;
            if (col_q == IDX_W'(GRID_SIZE - 2)) begin
              col_q <= IDX_W'(1);
              row_q <= row_q + IDX_W'(1);
            end else begin
              col_q <= col_q + IDX_W'(1);
            end
          end else begin
            step_q <= sstep_e'(step_q + 3'd1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_H2) begin
      h2_q <= grid_step_q * grid_step_q;
    end
    if (state_q == ST_H4) begin
      h4_q <= H4_W'(((2*H2_W+1)'(h2_q) * (2*H2_W+1)'(h2_q) + (2*H2_W+1)'(32768)) >> 16);
    end
    if (state_q == ST_INIT_MUL) begin
      r2_q     <= (SQ_W+H2_W+1)'(r2_idx) * (SQ_W+H2_W+1)'(h2_q);
      border_q <= (row_q == '0) || (col_q == '0)
               || (row_q == IDX_W'(GRID_SIZE - 1)) || (col_q == IDX_W'(GRID_SIZE - 1));
    end
    if (state_q == ST_SWEEP) begin
      unique case (step_q)
        SS_C: begin
          m_q   <= m_d;
          neg_q <= d_s[SQ_W+1];
        end
        SS_N: pl_q <= (M_W+32)'(m_q) * (M_W+32)'(h4_q[31:0]);
        SS_S: begin
          n_q  <= ram_rdata[VAL_W-1:0];
          ph_q <= (M_W+H4_W-32)'(m_q) * (M_W+H4_W-32)'(h4_q[H4_W-1:32]);
        end
        SS_W: begin
          s_q    <= ram_rdata[VAL_W-1:0];
          term_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
        SS_E:  w_q <= ram_rdata[VAL_W-1:0];
        SS_LD: e_q <= ram_rdata[VAL_W-1:0];
        default: begin
        end
      endcase
    end
    if (state_q == ST_DONE && out_free) begin
      if (op_q == OP_READ && rd_ok_q) begin
        out_value_q  <= ram_rdata[VAL_W-1:0];
        out_inside_q <= ram_rdata[VAL_W];
      end else begin
        out_value_q  <= '0;
        out_inside_q <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/pgs_ram.sv
// ----------------------------------------------------------------------------
// pgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pgs_checker.sv
// ----------------------------------------------------------------------------
// pgs_checker
// Port-level checks of the Poisson sweep block, bound to the top level.
// ----------------------------------------------------------------------------
module pgs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic        out_inside,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_inside))
    else $error("result word changed while stalled");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared in the cycle after accept");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid |-> cfg_ready)
    else $error("config write not taken");

endmodule

bind poisson_gauss_seidel_sweep pgs_checker u_pgs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_value (out_o.cell_value),
  .out_inside(out_o.cell_inside),
  .cfg_valid (cfg_i.valid),
  .cfg_ready (cfg_i.ready)
);
